// ===== hdl/crmt_pkg.sv =====
// ----------------------------------------------------------------------------
// crmt_pkg: shared types and constants for the cidr first-match table
// Table size, field widths, result status codes, the token that walks the
// cell chain and the host mask helper.
// ----------------------------------------------------------------------------
package crmt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = 32;
  localparam int PLEN_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int OUT_IDX_W   = 6;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd3;

  localparam logic [0:0] KIND_APPEND = 1'b0;
  localparam logic [0:0] KIND_LOOKUP = 1'b1;

  localparam logic [PLEN_W-1:0] PLEN_FULL = PLEN_W'(ADDR_W);

  // lookup token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } tok_t;

  // low host bits of a prefix; zero prefix covers everything,
  // prefixes of 32 and above leave the base alone
  function automatic logic [ADDR_W-1:0] host_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    if (plen == '0) begin
      m = '1;
    end else if (plen >= PLEN_FULL) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} >> plen;
    end
    return m;
  endfunction

endpackage

// ===== hdl/crmt_cell.sv =====
// ----------------------------------------------------------------------------
// crmt_cell: one table entry and one stage of the lookup chain
// Holds the low and high bound of an entry, compares the passing token's
// address against them and hands the token to the next cell.
// ----------------------------------------------------------------------------
module crmt_cell
  import crmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    cell_idx,
  input  logic [CNT_W-1:0]    entry_count,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [ADDR_W-1:0]   wr_base,
  input  logic [PLEN_W-1:0]   wr_prefix,
  input  tok_t                tok_in,
  output tok_t                tok_out
);

  logic [ADDR_W-1:0] lo_r;
  logic [ADDR_W-1:0] hi_r;
  logic              tok_vld_r;
  tok_t              tok_r;
  tok_t              tok_nxt;
  logic              active;
  logic              match;

  // upper bound is precomputed when the entry is written
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == cell_idx)) begin
      lo_r <= wr_base;
      hi_r <= wr_base | host_mask(wr_prefix);
    end
  end

  assign active = CNT_W'(cell_idx) < entry_count;
  assign match  = active && (tok_in.addr >= lo_r) && (tok_in.addr <= hi_r);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.hit && match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_comb begin
    tok_out     = tok_r;
    tok_out.vld = tok_vld_r;
  end

endmodule

// ===== hdl/cidr_range_first_match_table.sv =====
// ----------------------------------------------------------------------------
// cidr_range_first_match_table: first-match cidr range table
// Appends entries in load order and looks up an address by walking a token
// down a chain of entry cells, reporting the lowest matching index.
//
//   channel  | handshake      | beat contents
//   ---------+----------------+-----------------------------------------
//   input    | start / busy   | in_kind, in_address, in_prefix_len
//   result   | out_strobe     | out_status, out_entry_index
//
// append: accepted at start, result strobed the next cycle, busy stays low
// lookup: the token moves one cell a cycle; busy is raised by start and held
//   until the token leaves the last cell, then the result is registered and strobed
// a new item may start in the cycle its predecessor's result is strobed
// reset empties the table; the receiver cannot stall, results last one cycle
// ----------------------------------------------------------------------------
module cidr_range_first_match_table
  import crmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic [PLEN_W-1:0]     in_prefix_len,
  output logic                  out_strobe,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_IDX_W-1:0]  out_entry_index
);

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [OUT_IDX_W-1:0] index_r, index_nxt;

  logic accept;
  logic app_go;
  logic has_room;
  tok_t head;
  tok_t chain [TABLE_DEPTH+1];
  tok_t tail;

  assign accept   = start && !busy_r;
  assign has_room = count_r < CNT_W'(TABLE_DEPTH);
  assign app_go   = accept && (in_kind == KIND_APPEND) && has_room;

  always_comb begin
    head.vld  = accept && (in_kind == KIND_LOOKUP);
    head.hit  = 1'b0;
    head.idx  = '0;
    head.addr = in_address;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    crmt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .entry_count(count_r),
      .wr_en      (app_go),
      .wr_idx     (count_r[IDX_W-1:0]),
      .wr_base    (in_address),
      .wr_prefix  (in_prefix_len),
      .tok_in     (chain[i]),
      .tok_out    (chain[i+1])
    );
  end

  assign tail = chain[TABLE_DEPTH];

  always_comb begin
    busy_nxt   = busy_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    index_nxt  = index_r;
    if (tail.vld) begin
      busy_nxt   = 1'b0;
      strobe_nxt = 1'b1;
      status_nxt = tail.hit ? ST_HIT : ST_MISS;
      index_nxt  = tail.hit ? OUT_IDX_W'(tail.idx) : '0;
    end else if (accept) begin
      if (in_kind == KIND_LOOKUP) begin
        busy_nxt = 1'b1;
      end else begin
        strobe_nxt = 1'b1;
        if (has_room) begin
          status_nxt = ST_APPENDED;
          index_nxt  = OUT_IDX_W'(count_r);
          count_nxt  = count_r + CNT_W'(1);
        end else begin
          status_nxt = ST_FULL;
          index_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    index_r  <= index_nxt;
  end

  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_index = index_r;

endmodule

// ===== hdl/crmt_checker.sv =====
// ----------------------------------------------------------------------------
// crmt_checker: port-level checks for the cidr first-match table
// Watches the start/busy handshake and result beats over time.
// ----------------------------------------------------------------------------
module crmt_checker
  import crmt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_kind,
  input logic                  out_strobe,
  input logic [STATUS_W-1:0]   out_status,
  input logic [OUT_IDX_W-1:0]  out_entry_index
);

  // an append answers in the next cycle
  a_append_next: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == KIND_APPEND) |=> out_strobe &&
      (out_status == ST_APPENDED || out_status == ST_FULL))
    else $error("append beat not answered in the next cycle");

  // a lookup holds the port busy
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == KIND_LOOKUP) |=> busy && !out_strobe)
    else $error("lookup did not raise busy");

  // the end of a lookup always brings its result beat
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe &&
      (out_status == ST_HIT || out_status == ST_MISS))
    else $error("busy dropped without a lookup result");

  // no result beat while a lookup is still walking
  a_no_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_strobe && busy))
    else $error("result beat while busy");

  a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_FULL || out_status == ST_MISS)
      |-> out_entry_index == '0)
    else $error("nonzero index on full or miss");

endmodule

bind cidr_range_first_match_table crmt_checker u_crmt_checker (.*);
